@@ rtl/core/ame_pkg.sv @@
// ----------------------------------------------------------------------------
// ame_pkg
// Shared types, constants and helpers of the alarm annunciator.
// ----------------------------------------------------------------------------
package ame_pkg;

  localparam int NUM_SOURCES = 8;
  localparam int SRC_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int MUTE_LIMIT_DEFAULT = 3;
  localparam int THR_W = 4;
  localparam int CNT_W = 4;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE       = 2'd0,
    ST_ON         = 2'd1,
    ST_SUPPRESSED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CMD_RAISE = 2'd0,
    CMD_MUTE  = 2'd1,
    CMD_RESET = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic {
    DISP_SHOW  = 1'b0,
    DISP_CLEAR = 1'b1
  } disp_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_SCAN,
    S_EMIT
  } state_t;

  typedef struct packed {
    status_t          status;
    logic [CNT_W-1:0] count;
  } entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [SRC_W-1:0] rd_addr;
    logic             wr_en;
    logic [SRC_W-1:0] wr_addr;
    entry_t           wr_data;
    logic             clear;
  } mem_req_t;

  typedef struct packed {
    disp_t      event_kind;
    logic [2:0] alarm;
    logic       beep;
    logic       last_flag;
  } result_t;

  function automatic logic [SRC_W-1:0] lowest_on(input logic [NUM_SOURCES-1:0] v);
    logic [SRC_W-1:0] r;
    r = '0;
    for (int i = NUM_SOURCES - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = SRC_W'(i);
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/core/alarm_annunciator_mute_escalation.sv @@
// ----------------------------------------------------------------------------
// alarm_annunciator_mute_escalation
// Alarm annunciator with per-source mute counting and escalation to ignored.
// A raise that shows an alarm reads its entry, writes it back, runs the
// priority scan and delivers its transaction; a mute delivers its display-off
// and, if other sources are still on, a promoted display-on after a scan; a
// reset command answers directly. One command at a time, paced by the registered
// read of the source store, its write-back, the priority scan and output stalls.
// Reset clears all sources, the active alarm and the output valid flag at once.
// ----------------------------------------------------------------------------
module alarm_annunciator_mute_escalation (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [1:0]  command,
  input  logic [2:0]  alarm_index,
  output logic        result_valid,
  input  logic        result_ready,
  output logic        display_event,
  output logic [2:0]  shown_alarm,
  output logic        beep_on,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ame_pkg::*;

  logic [THR_W-1:0] threshold;
  mem_req_t         mem_req;
  entry_t           mem_rd;
  result_t          result;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? 32'(threshold) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THR_W'(MUTE_LIMIT_DEFAULT);
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      threshold <= pwdata[THR_W-1:0];
    end
  end

  ame_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .threshold    (threshold),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .command      (command),
    .alarm_index  (alarm_index),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .mem_req      (mem_req),
    .mem_rd       (mem_rd)
  );

  ame_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .req     (mem_req),
    .rd_data (mem_rd)
  );

  assign display_event = result.event_kind;
  assign shown_alarm   = result.alarm;
  assign beep_on       = result.beep;
  assign last          = result.last_flag;

endmodule

@@ rtl/core/ame_mem.sv @@
// ----------------------------------------------------------------------------
// ame_mem
// Per-source status and mute count store with registered read.
// Entries that were never written since a clear read as idle with count zero.
// ----------------------------------------------------------------------------
module ame_mem (
  input  logic             clk,
  input  logic             rst,
  input  ame_pkg::mem_req_t req,
  output ame_pkg::entry_t  rd_data
);
  import ame_pkg::*;

  entry_t                 mem [NUM_SOURCES];
  logic [NUM_SOURCES-1:0] valid;
  entry_t                 data_q;
  logic                   valid_q;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      data_q <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (req.clear) begin
        valid <= '0;
      end else if (req.wr_en) begin
        valid[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        valid_q <= valid[req.rd_addr];
      end
    end
  end

  always_comb begin
    if (valid_q) begin
      rd_data = data_q;
    end else begin
      rd_data = '{status: ST_IDLE, count: '0};
    end
  end

endmodule

@@ rtl/core/ame_ctrl.sv @@
// ----------------------------------------------------------------------------
// ame_ctrl
// Command sequencer: reads the addressed entry, updates it, keeps the pending
// mask and the active alarm, and hands display transactions to the output
// register.
// ----------------------------------------------------------------------------
module ame_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [ame_pkg::THR_W-1:0] threshold,
  input  logic                      item_valid,
  output logic                      item_ready,
  input  logic [1:0]                command,
  input  logic [2:0]                alarm_index,
  output logic                      result_valid,
  input  logic                      result_ready,
  output ame_pkg::result_t          result,
  output ame_pkg::mem_req_t         mem_req,
  input  ame_pkg::entry_t           mem_rd
);
  import ame_pkg::*;

  state_t                 state;
  state_t                 state_next;
  cmd_t                   cmd_q;
  logic [SRC_W-1:0]       addr_q;
  logic [NUM_SOURCES-1:0] on_vec;
  logic                   active_valid;
  logic [SRC_W-1:0]       active_alarm;
  result_t                res;
  logic                   res_more;

  logic                   accept;
  cmd_t                   cmd_in;
  logic                   raise_ok;
  logic [SRC_W-1:0]       rd_addr;
  logic                   raise_go;
  logic                   mute_go;
  logic [CNT_W-1:0]       cnt_inc;
  logic [NUM_SOURCES-1:0] rest_on;
  logic                   slot_free;
  logic [SRC_W-1:0]       lowest;

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;
  assign cmd_in     = cmd_t'(command);
  assign raise_ok   = int'(alarm_index) < NUM_SOURCES;
  assign rd_addr    = (cmd_in == CMD_MUTE) ? active_alarm : SRC_W'(alarm_index);
  assign raise_go   = (cmd_q == CMD_RAISE) && (mem_rd.status != ST_SUPPRESSED);
  assign mute_go    = (cmd_q == CMD_MUTE) && (mem_rd.status == ST_ON);
  assign cnt_inc    = (mem_rd.count == CNT_MAX) ? CNT_MAX : mem_rd.count + 1'b1;
  assign rest_on    = on_vec & ~(NUM_SOURCES'(1) << addr_q);
  assign slot_free  = !result_valid || result_ready;
  assign lowest     = lowest_on(on_vec);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd_in)
            CMD_RAISE: state_next = raise_ok ? S_LOOK : S_IDLE;
            CMD_MUTE:  state_next = active_valid ? S_LOOK : S_IDLE;
            CMD_RESET: state_next = S_EMIT;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_LOOK: begin
        if (raise_go && !active_valid) begin
          state_next = S_SCAN;
        end else if (mute_go) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SCAN: state_next = S_EMIT;
      S_EMIT: begin
        if (slot_free) begin
          state_next = res_more ? S_SCAN : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    mem_req         = '0;
    mem_req.rd_en   = accept;
    mem_req.rd_addr = rd_addr;
    mem_req.clear   = accept && (cmd_in == CMD_RESET);
    mem_req.wr_addr = addr_q;
    case (state)
      S_LOOK: begin
        mem_req.wr_en = raise_go || mute_go;
        if (cmd_q == CMD_RAISE) begin
          mem_req.wr_data = '{status: ST_ON, count: mem_rd.count};
        end else begin
          mem_req.wr_data.count  = cnt_inc;
          mem_req.wr_data.status = (cnt_inc >= threshold) ? ST_SUPPRESSED : ST_IDLE;
        end
      end
      default: mem_req.wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= cmd_in;
      addr_q <= rd_addr;
    end
    if (state == S_EMIT && slot_free) begin
      result <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      on_vec       <= '0;
      active_valid <= 1'b0;
      active_alarm <= '0;
      res          <= '0;
      res_more     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (accept && cmd_in == CMD_RESET) begin
        on_vec       <= '0;
        active_valid <= 1'b0;
        active_alarm <= '0;
        res          <= '{event_kind: DISP_CLEAR, alarm: 3'd0, beep: 1'b0, last_flag: 1'b1};
        res_more     <= 1'b0;
      end
      if (state == S_LOOK && raise_go) begin
        on_vec[addr_q] <= 1'b1;
      end
      if (state == S_LOOK && mute_go) begin
        on_vec[addr_q] <= 1'b0;
        active_valid   <= 1'b0;
        active_alarm   <= '0;
        res            <= '{event_kind: DISP_CLEAR, alarm: 3'd0, beep: 1'b0,
                            last_flag: (rest_on == '0)};
        res_more       <= (rest_on != '0);
      end
      if (state == S_SCAN) begin
        active_valid <= 1'b1;
        active_alarm <= lowest;
        res          <= '{event_kind: DISP_SHOW, alarm: 3'(lowest), beep: 1'b1,
                          last_flag: 1'b1};
        res_more     <= 1'b0;
      end
      if (state == S_EMIT && slot_free) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule
